// File: rtl/maolp_pkg.sv
package maolp_pkg;

   localparam int AXES      = 4;
   localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int EST_W     = 18;
   localparam int POS_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_DAT_W = 32;
   localparam int RSP_DAT_W = 80;

   localparam logic [7:0] CMD_DRIVE = 8'h40;
   localparam logic [7:0] CMD_STOP  = 8'h41;
   localparam logic [7:0] CMD_GOTO  = 8'h42;

   localparam logic [7:0] DRIVE_ARG_FWD = 8'd1;
   localparam logic [7:0] DRIVE_ARG_REV = 8'd2;

   localparam logic [CSR_IDX_W-1:0] REG_POS_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POS_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOMING_TICK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SAVE_PERIOD = 3'd5;

   localparam logic [15:0] POS_MAX_RESET = 16'd1000;

   localparam logic signed [EST_W:0] EST_HI = 19'sd131071;
   localparam logic signed [EST_W:0] EST_LO = -19'sd131072;

   typedef enum logic [1:0] {
      DIR_OFF = 2'd0,
      DIR_FWD = 2'd1,
      DIR_REV = 2'd2
   } dir_type;

   typedef struct packed {
      logic [15:0] pos_min;
      logic [15:0] pos_max;
      logic [11:0] deadband;
      logic [7:0]  step;
      logic [15:0] homing_ticks;
      logic [7:0]  save_period;
   } cfg_type;

   // per-axis update controls, qualified by the advance of the request stage
   typedef struct packed {
      logic              dir_we;
      dir_type           dir;
      logic              tgt_we;
      logic [POS_W-1:0]  tgt;
      logic              home_step;
      logic              home_done;
      logic              track;
   } axis_ctrl_type;

   typedef logic [255:0][AXIS_W-1:0] axis_table_type;

   function automatic axis_table_type build_axis_table();
      axis_table_type t;
      for (int k = 0; k < 256; k++) begin
         t[k] = AXIS_W'(k % AXES);
      end
      return t;
   endfunction

   localparam axis_table_type AXIS_TABLE = build_axis_table();

   // below the minimum gives the minimum, otherwise above the maximum gives the maximum
   function automatic logic [POS_W-1:0] clamp_pos(logic signed [EST_W:0] v,
                                                  logic [15:0] lo, logic [15:0] hi);
      logic signed [EST_W:0] lo_s;
      logic signed [EST_W:0] hi_s;
      lo_s = $signed({3'b000, lo});
      hi_s = $signed({3'b000, hi});
      if (v < lo_s) begin
         return lo;
      end else if (v > hi_s) begin
         return hi;
      end
      return v[POS_W-1:0];
   endfunction

   function automatic logic signed [EST_W-1:0] sat_est(logic signed [EST_W:0] v);
      if (v > EST_HI) begin
         return EST_HI[EST_W-1:0];
      end else if (v < EST_LO) begin
         return EST_LO[EST_W-1:0];
      end
      return v[EST_W-1:0];
   endfunction

endpackage

// File: rtl/maolp_csr.sv
module maolp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [maolp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [maolp_pkg::CSR_DAT_W-1:0]     csr_data,
   output maolp_pkg::cfg_type                  cfg
);

   maolp_pkg::cfg_type cfg_ff;
   maolp_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            maolp_pkg::REG_POS_MIN:     cfg_in.pos_min      = csr_data;
            maolp_pkg::REG_POS_MAX:     cfg_in.pos_max      = csr_data;
            maolp_pkg::REG_DEADBAND:    cfg_in.deadband     = csr_data[11:0];
            maolp_pkg::REG_STEP:        cfg_in.step         = csr_data[7:0];
            maolp_pkg::REG_HOMING_TICK: cfg_in.homing_ticks = csr_data;
            maolp_pkg::REG_SAVE_PERIOD: cfg_in.save_period  = csr_data[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_min      <= 16'd0;
         cfg_ff.pos_max      <= maolp_pkg::POS_MAX_RESET;
         cfg_ff.deadband     <= 12'd5;
         cfg_ff.step         <= 8'd1;
         cfg_ff.homing_ticks <= 16'd500;
         cfg_ff.save_period  <= 8'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/maolp_axis.sv
module maolp_axis (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  maolp_pkg::cfg_type               cfg,
   input  maolp_pkg::axis_ctrl_type         ctrl,
   output maolp_pkg::dir_type               dir_next,
   output logic [maolp_pkg::POS_W-1:0]      pos_next
);

   logic signed [maolp_pkg::EST_W-1:0] est_ff, est_in;
   logic [maolp_pkg::POS_W-1:0]        tgt_ff, tgt_in;
   maolp_pkg::dir_type                 dir_ff, dir_in;

   logic signed [maolp_pkg::EST_W:0] est_x;
   logic signed [maolp_pkg::EST_W:0] step_x;
   logic signed [maolp_pkg::EST_W:0] db_x;
   logic signed [maolp_pkg::EST_W:0] err;

   always_comb begin
      est_x  = {est_ff[maolp_pkg::EST_W-1], est_ff};
      step_x = $signed({11'd0, cfg.step});
      db_x   = $signed({7'd0, cfg.deadband});
      err    = $signed({3'b000, tgt_ff}) - est_x;

      est_in = est_ff;
      tgt_in = tgt_ff;
      dir_in = dir_ff;

      if (ctrl.dir_we) begin
         dir_in = ctrl.dir;
      end
      if (ctrl.tgt_we) begin
         tgt_in = ctrl.tgt;
      end
      // homing drives forward, which counts the estimate down
      if (ctrl.home_step && dir_ff == maolp_pkg::DIR_FWD) begin
         est_in = maolp_pkg::sat_est(est_x - step_x);
      end
      if (ctrl.home_done) begin
         dir_in = maolp_pkg::DIR_OFF;
         est_in = $signed({2'b00, cfg.pos_min});
      end
      if (ctrl.track) begin
         priority if (err > db_x) begin
            dir_in = maolp_pkg::DIR_FWD;
            est_in = maolp_pkg::sat_est(est_x + step_x);
         end else if (err < -db_x) begin
            dir_in = maolp_pkg::DIR_REV;
            est_in = maolp_pkg::sat_est(est_x - step_x);
         end else begin
            dir_in = maolp_pkg::DIR_OFF;
         end
      end
   end

   assign dir_next = dir_in;
   assign pos_next = maolp_pkg::clamp_pos({est_in[maolp_pkg::EST_W-1], est_in},
                                          cfg.pos_min, cfg.pos_max);

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
         tgt_ff <= '0;
         dir_ff <= maolp_pkg::DIR_FWD;
      end else if (advance) begin
         est_ff <= est_in;
         tgt_ff <= tgt_in;
         dir_ff <= dir_in;
      end
   end

endmodule

// File: rtl/multi_axis_open_loop_positioner.sv
// Channel  Ports                         Direction  Payload
// req      req_tvalid/tready/tdata/tuser in         command frame or control tick
// rsp      rsp_tvalid/tready/tdata       out        directions, positions, flags
// csr      csr_valid/ready/index/data    in         register write, always ready
//
// One request per cycle sustained while rsp_tready stays high. A request is latched
// in an input register; when it advances it updates the axis state and loads its
// response into the output register at the same edge.
// The input register advances whenever the output register is empty or being
// taken, so rsp_tready low stalls both stages without losing a request.
// Synchronous reset puts every axis in forward homing with zero estimates.
module multi_axis_open_loop_positioner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] command_code, [15:8] axis_byte, [23:16] argument_high, [31:24] argument_low
   input  logic [maolp_pkg::REQ_DAT_W-1:0]     req_tdata,
   // [0] op
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] direction_axis0, [3:2] direction_axis1, [5:4] direction_axis2,
   // [7:6] direction_axis3, [23:8] position_axis0, [39:24] position_axis1,
   // [55:40] position_axis2, [71:56] position_axis3, [72] homing_flag,
   // [73] save_pulse, [79:74] zero
   output logic [maolp_pkg::RSP_DAT_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [maolp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [maolp_pkg::CSR_DAT_W-1:0]     csr_data
);

   maolp_pkg::cfg_type cfg;

   maolp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   logic                                in_valid_ff;
   logic                                in_op_ff;
   logic [maolp_pkg::REQ_DAT_W-1:0]     in_data_ff;
   logic                                out_valid_ff;
   logic [maolp_pkg::RSP_DAT_W-1:0]     out_data_ff, out_data_in;
   logic                                advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // request decode
   logic [7:0]                   code;
   logic [7:0]                   arg_hi;
   logic [7:0]                   arg_lo;
   logic [maolp_pkg::AXIS_W-1:0] axis_sel;
   maolp_pkg::dir_type           drive_dir;
   logic                         is_cmd;
   logic                         is_tick;

   assign code     = in_data_ff[7:0];
   assign axis_sel = maolp_pkg::AXIS_TABLE[in_data_ff[15:8]];
   assign arg_hi   = in_data_ff[23:16];
   assign arg_lo   = in_data_ff[31:24];
   assign is_cmd   = advance && !in_op_ff;
   assign is_tick  = advance && in_op_ff;

   always_comb begin
      priority if (arg_hi == maolp_pkg::DRIVE_ARG_FWD) begin
         drive_dir = maolp_pkg::DIR_FWD;
      end else if (arg_hi == maolp_pkg::DRIVE_ARG_REV) begin
         drive_dir = maolp_pkg::DIR_REV;
      end else begin
         drive_dir = maolp_pkg::DIR_OFF;
      end
   end

   // homing and save timers
   logic        homing_active_ff, homing_active_in;
   logic [15:0] homing_elapsed_ff, homing_elapsed_in;
   logic [7:0]  save_elapsed_ff, save_elapsed_in;
   logic [15:0] homing_inc;
   logic [7:0]  save_inc;
   logic        home_step;
   logic        home_done;
   logic        track;
   logic        save;

   always_comb begin
      homing_inc = (homing_elapsed_ff == 16'hFFFF) ? homing_elapsed_ff
                                                   : homing_elapsed_ff + 16'd1;
      save_inc   = (save_elapsed_ff == 8'hFF) ? save_elapsed_ff : save_elapsed_ff + 8'd1;

      home_step         = is_tick && homing_active_ff;
      home_done         = home_step && (homing_inc >= cfg.homing_ticks);
      track             = is_tick && !homing_active_ff;

      homing_active_in  = homing_active_ff;
      homing_elapsed_in = homing_elapsed_ff;
      save_elapsed_in   = save_elapsed_ff;
      save              = 1'b0;

      if (home_step) begin
         homing_elapsed_in = homing_inc;
      end
      if (home_done) begin
         homing_active_in = 1'b0;
         save             = 1'b1;
      end
      if (track) begin
         if (save_inc >= cfg.save_period) begin
            save_elapsed_in = 8'd0;
            save            = 1'b1;
         end else begin
            save_elapsed_in = save_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         homing_active_ff  <= 1'b1;
         homing_elapsed_ff <= 16'd0;
         save_elapsed_ff   <= 8'd0;
      end else begin
         homing_active_ff  <= homing_active_in;
         homing_elapsed_ff <= homing_elapsed_in;
         save_elapsed_ff   <= save_elapsed_in;
      end
   end

   // axes
   maolp_pkg::dir_type          dir_next [maolp_pkg::AXES];
   logic [maolp_pkg::POS_W-1:0] pos_next [maolp_pkg::AXES];

   for (genvar a = 0; a < maolp_pkg::AXES; a++) begin : g_axis
      maolp_pkg::axis_ctrl_type ctrl;
      logic                     hit;

      assign hit            = is_cmd && (axis_sel == maolp_pkg::AXIS_W'(a));
      assign ctrl.dir_we    = hit && (code == maolp_pkg::CMD_DRIVE || code == maolp_pkg::CMD_STOP);
      assign ctrl.dir       = (code == maolp_pkg::CMD_DRIVE) ? drive_dir : maolp_pkg::DIR_OFF;
      assign ctrl.tgt_we    = hit && (code == maolp_pkg::CMD_GOTO);
      assign ctrl.tgt       = maolp_pkg::clamp_pos($signed({3'b000, arg_hi, arg_lo}),
                                                   cfg.pos_min, cfg.pos_max);
      assign ctrl.home_step = home_step;
      assign ctrl.home_done = home_done;
      assign ctrl.track     = track;

      maolp_axis u_axis (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cfg      (cfg),
         .ctrl     (ctrl),
         .dir_next (dir_next[a]),
         .pos_next (pos_next[a])
      );
   end

   // response packing, slots past the axis count read as zero
   for (genvar s = 0; s < 4; s++) begin : g_pack
      if (s < maolp_pkg::AXES) begin : g_used
         assign out_data_in[2*s +: 2]   = dir_next[s];
         assign out_data_in[8+16*s +: 16] = pos_next[s];
      end else begin : g_unused
         assign out_data_in[2*s +: 2]   = 2'b00;
         assign out_data_in[8+16*s +: 16] = 16'd0;
      end
   end

   assign out_data_in[72]    = homing_active_in;
   assign out_data_in[73]    = save;
   assign out_data_in[79:74] = 6'd0;

endmodule

// File: sim/tb_multi_axis_open_loop_positioner.sv
`timescale 1ns / 1ps

module tb_multi_axis_open_loop_positioner;
   import maolp_pkg::*;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TICK  = 1'b1;
   localparam int unsigned LONG_HOLD = 80;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_style_type;

   typedef struct packed {
      logic       op;
      logic [7:0] code;
      logic [7:0] axis_sel;
      logic [7:0] arg_hi;
      logic [7:0] arg_lo;
   } positioner_request_type;

   typedef struct packed {
      logic             save;
      logic             homing;
      logic [3:0][15:0] pos;
      logic [3:0][1:0]  dir;
   } axis_report_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_DAT_W-1:0] req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DAT_W-1:0] rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   // positioner state as the block should hold it
   cfg_type     cfg;
   int          est_pos [AXES];
   logic [15:0] target_pos [AXES];
   dir_type     drive_dir [AXES];
   logic        homing_on;
   int unsigned homing_count;
   int unsigned save_count;

   axis_report_type expected_reports[$];
   int unsigned     mismatch_count = 0;

   // sender and receiver pacing
   int unsigned     burst_left = 0;
   int unsigned     max_gap = 0;
   ready_style_type rsp_mode = READY_ALWAYS;
   int unsigned     hold_requests = 0;
   int unsigned     hold_served = 0;
   int unsigned     hold_left = 0;
   int unsigned     rsp_cycle = 0;

   multi_axis_open_loop_positioner uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] clamp_to_range(input int v);
      int lo;
      int hi;
      lo = cfg.pos_min;
      hi = cfg.pos_max;
      if (v < lo) begin
         return cfg.pos_min;
      end
      if (v > hi) begin
         return cfg.pos_max;
      end
      return v[15:0];
   endfunction

   function automatic int saturate_estimate(input int v);
      if (v > 131071) begin
         return 131071;
      end
      if (v < -131072) begin
         return -131072;
      end
      return v;
   endfunction

   function automatic axis_report_type advance_positioner(input positioner_request_type r);
      axis_report_type rep;
      int              axis;
      int              err;
      int              db;
      int              step;
      logic            save;
      axis = r.axis_sel % AXES;
      db   = cfg.deadband;
      step = cfg.step;
      save = 1'b0;
      if (r.op == OP_FRAME) begin
         case (r.code)
            CMD_DRIVE: begin
               if (r.arg_hi == DRIVE_ARG_FWD) begin
                  drive_dir[axis] = DIR_FWD;
               end else if (r.arg_hi == DRIVE_ARG_REV) begin
                  drive_dir[axis] = DIR_REV;
               end else begin
                  drive_dir[axis] = DIR_OFF;
               end
            end
            CMD_STOP: drive_dir[axis] = DIR_OFF;
            CMD_GOTO: target_pos[axis] = clamp_to_range({r.arg_hi, r.arg_lo});
            default: ;
         endcase
      end else if (homing_on) begin
         if (homing_count < 16'hFFFF) begin
            homing_count++;
         end
         // forward drive lowers the estimate during homing
         for (int i = 0; i < AXES; i++) begin
            if (drive_dir[i] == DIR_FWD) begin
               est_pos[i] = saturate_estimate(est_pos[i] - step);
            end
         end
         if (homing_count >= cfg.homing_ticks) begin
            for (int i = 0; i < AXES; i++) begin
               drive_dir[i] = DIR_OFF;
               est_pos[i]   = cfg.pos_min;
            end
            homing_on = 1'b0;
            save      = 1'b1;
         end
      end else begin
         for (int i = 0; i < AXES; i++) begin
            err = int'(target_pos[i]) - est_pos[i];
            if (err > db) begin
               drive_dir[i] = DIR_FWD;
               est_pos[i]   = saturate_estimate(est_pos[i] + step);
            end else if (err < -db) begin
               drive_dir[i] = DIR_REV;
               est_pos[i]   = saturate_estimate(est_pos[i] - step);
            end else begin
               drive_dir[i] = DIR_OFF;
            end
         end
         if (save_count < 255) begin
            save_count++;
         end
         if (save_count >= cfg.save_period) begin
            save_count = 0;
            save       = 1'b1;
         end
      end
      for (int i = 0; i < AXES; i++) begin
         rep.dir[i] = drive_dir[i];
         rep.pos[i] = clamp_to_range(est_pos[i]);
      end
      rep.homing = homing_on;
      rep.save   = save;
      return rep;
   endfunction

   function automatic positioner_request_type random_request();
      positioner_request_type r;
      int unsigned            pick;
      logic [15:0]            target;
      r.op       = OP_FRAME;
      r.code     = 8'($urandom);
      r.axis_sel = 8'($urandom);
      r.arg_hi   = 8'($urandom);
      r.arg_lo   = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.op = OP_TICK;
      end else if (pick < 60) begin
         r.code = CMD_DRIVE;
         if (pick < 56) begin
            r.arg_hi = 8'($urandom_range(2));
         end
      end else if (pick < 66) begin
         r.code = CMD_STOP;
      end else if (pick < 88) begin
         r.code = CMD_GOTO;
         if (pick < 84 && cfg.pos_min <= cfg.pos_max) begin
            target = 16'($urandom_range(cfg.pos_max, cfg.pos_min));
         end else begin
            target = 16'($urandom);
         end
         {r.arg_hi, r.arg_lo} = target;
      end
      // the rest is noise: random codes, mostly unknown
      return r;
   endfunction

   task automatic send_request(input positioner_request_type r);
      if (burst_left == 0) begin
         if (max_gap != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(max_gap, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {r.arg_lo, r.arg_hi, r.axis_sel, r.code};
      do @(posedge clock); while (!req_tready);
      expected_reports.push_back(advance_positioner(r));
   endtask

   task automatic send_fields(input logic op, input logic [7:0] code, input logic [7:0] axis_sel,
                              input logic [7:0] arg_hi, input logic [7:0] arg_lo);
      positioner_request_type r;
      r = '{op: op, code: code, axis_sel: axis_sel, arg_hi: arg_hi, arg_lo: arg_lo};
      send_request(r);
   endtask

   task automatic wait_drained();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
      end
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // writes all six registers back to back; call only with the block drained
   task automatic configure(input logic [15:0] min_v, input logic [15:0] max_v,
                            input logic [15:0] db_v, input logic [15:0] step_v,
                            input logic [15:0] home_v, input logic [15:0] save_v);
      logic [CSR_IDX_W-1:0] idx [6];
      logic [15:0]          vals [6];
      idx  = '{REG_POS_MIN, REG_POS_MAX, REG_DEADBAND, REG_STEP, REG_HOMING_TICK,
               REG_SAVE_PERIOD};
      vals = '{min_v, max_v, db_v, step_v, home_v, save_v};
      for (int k = 0; k < 6; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= vals[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg.pos_min      = min_v;
      cfg.pos_max      = max_v;
      cfg.deadband     = db_v[11:0];
      cfg.step         = step_v[7:0];
      cfg.homing_ticks = home_v;
      cfg.save_period  = save_v[7:0];
   endtask

   task automatic run_random_phase(input int unsigned count, input int unsigned gap,
                                   input ready_style_type mode);
      max_gap  = gap;
      rsp_mode = mode;
      repeat (count) send_request(random_request());
   endtask

   // commands stay live while homing; large step and a long homing count
   task automatic test_homing_commands();
      configure(16'd0, POS_MAX_RESET, 16'd5, 16'd255, 16'hFFFF, 16'd100);
      max_gap  = 2;
      rsp_mode = READY_PATTERN;
      send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(OP_FRAME, CMD_DRIVE, 8'h01, DRIVE_ARG_REV, 8'h00);
      send_fields(OP_FRAME, CMD_DRIVE, 8'hFE, 8'h00, 8'hFF);
      send_fields(OP_FRAME, CMD_DRIVE, 8'hFF, 8'hFF, 8'h00);
      send_fields(OP_FRAME, CMD_DRIVE, 8'h80, DRIVE_ARG_FWD, 8'h00);
      send_fields(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_fields(OP_FRAME, CMD_STOP, 8'h07, 8'h00, 8'h00);
      send_fields(OP_FRAME, CMD_GOTO, 8'h00, 8'hFF, 8'hFF);
      send_fields(OP_FRAME, CMD_GOTO, 8'h01, 8'h00, 8'h00);
      send_fields(OP_FRAME, CMD_GOTO, 8'h02, 8'h01, 8'hF4);
      send_fields(OP_FRAME, CMD_GOTO, 8'h03, 8'h03, 8'hE9);
      send_fields(OP_FRAME, 8'h00, 8'h00, 8'h02, 8'h00);
      send_fields(OP_FRAME, 8'hFF, 8'hFF, 8'h01, 8'hFF);
      send_fields(OP_FRAME, 8'h3F, 8'h02, 8'h02, 8'h55);
      send_fields(OP_FRAME, 8'h43, 8'h01, 8'h01, 8'hAA);
      send_fields(OP_FRAME, CMD_DRIVE, 8'h06, DRIVE_ARG_FWD, 8'h00);
      repeat (6) send_fields(OP_TICK, CMD_GOTO, 8'($urandom), 8'($urandom), 8'($urandom));
      wait_drained();
   endtask

   // a zero homing count ends homing on the next tick
   task automatic test_homing_exit();
      configure(16'd0, POS_MAX_RESET, 16'd5, 16'd1, 16'd0, 16'd100);
      max_gap = 0;
      send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_drained();
   endtask

   task automatic test_tracking();
      configure(16'd0, POS_MAX_RESET, 16'd5, 16'd25, 16'd500, 16'd10);
      run_random_phase(60, 0, READY_ALWAYS);
      run_random_phase(170, 6, READY_RANDOM);
      wait_drained();
   endtask

   // full range, no deadband, largest step, save on every tick
   task automatic test_wide_range();
      configure(16'd0, 16'hFFFF, 16'd0, 16'd255, 16'd1, 16'd0);
      run_random_phase(110, 3, READY_PATTERN);
      wait_drained();
   endtask

   // minimum above maximum, widest deadband, no motion, longest save period
   task automatic test_inverted_range();
      configure(16'd40000, 16'd100, 16'hFFF, 16'd0, 16'd1, 16'd255);
      run_random_phase(70, 8, READY_RANDOM);
      wait_drained();
   endtask

   task automatic test_random_settings();
      logic [15:0] lo;
      for (int k = 0; k < 3; k++) begin
         lo = 16'($urandom_range(3000));
         if (k == 2) begin
            // unused upper data bits are driven with random values on purpose
            configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
         end else begin
            configure(lo, lo + 16'($urandom_range(3000)), 16'($urandom_range(40)),
                      16'($urandom_range(60)), 16'($urandom_range(65535, 1)),
                      16'($urandom_range(30)));
         end
         run_random_phase(55, k * 4, (k == 1) ? READY_PATTERN : READY_RANDOM);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      configure(16'd100, 16'd900, 16'd3, 16'd4, 16'd1, 16'd3);
      max_gap  = 0;
      rsp_mode = READY_ALWAYS;
      hold_requests <= hold_requests + 1;
      repeat (30) send_request(random_request());
      // sender waits for all responses before going on
      wait_drained();
      run_random_phase(20, 2, READY_RANDOM);
      wait_drained();
   endtask

   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else begin
         case (rsp_mode)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_RANDOM:  rsp_tready <= ($urandom_range(3) != 0);
            READY_PATTERN: rsp_tready <= ((rsp_cycle % 11) < 6);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin : check_response
      axis_report_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $error("response with none outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            wanted = expected_reports.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (rsp_tdata[2*i +: 2] !== wanted.dir[i]) begin
                  $error("direction_axis%0d expected %0d actual %0d", i, wanted.dir[i],
                         rsp_tdata[2*i +: 2]);
                  mismatch_count++;
               end
               if (rsp_tdata[8+16*i +: 16] !== wanted.pos[i]) begin
                  $error("position_axis%0d expected %0d actual %0d", i, wanted.pos[i],
                         rsp_tdata[8+16*i +: 16]);
                  mismatch_count++;
               end
            end
            if (rsp_tdata[72] !== wanted.homing) begin
               $error("homing_flag expected %0d actual %0d", wanted.homing, rsp_tdata[72]);
               mismatch_count++;
            end
            if (rsp_tdata[73] !== wanted.save) begin
               $error("save_pulse expected %0d actual %0d", wanted.save, rsp_tdata[73]);
               mismatch_count++;
            end
            if (rsp_tdata[79:74] !== 6'd0) begin
               $error("padding expected 0 actual %0d", rsp_tdata[79:74]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_FRAME;
      csr_valid  <= 1'b0;
      csr_index  <= REG_POS_MIN;
      csr_data   <= '0;
      cfg = '{pos_min: 16'd0, pos_max: POS_MAX_RESET, deadband: 12'd5, step: 8'd1,
              homing_ticks: 16'd500, save_period: 8'd100};
      for (int i = 0; i < AXES; i++) begin
         est_pos[i]    = 0;
         target_pos[i] = '0;
         drive_dir[i]  = DIR_FWD;
      end
      homing_on    = 1'b1;
      homing_count = 0;
      save_count   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_homing_commands();
      test_homing_exit();
      test_tracking();
      test_wide_range();
      test_inverted_range();
      test_random_settings();
      test_backpressure();
      wait_drained();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
